FILE: rtl/arpc_pkg.sv
// arpc_pkg: shared types, codes and constants of the arp cache engine
// no dependencies
package arpc_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;
    localparam int unsigned MAX_EVENTS        = 16;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned CFG_DATA_W        = 48;
    localparam int unsigned QUEUE_DEPTH       = 2;

    localparam logic [31:0] BCAST_IP   = 32'hFFFF_FFFF;
    localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
    localparam logic [10:0] MIN_FRAME  = 11'd42;
    localparam logic [15:0] HTYPE_ETH  = 16'd1;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_OP_REQ = 16'd1;

    typedef enum logic [2:0] {
        CFG_HOST_IP       = 3'd0,
        CFG_HOST_MAC      = 3'd1,
        CFG_ENTRY_TIMEOUT = 3'd2,
        CFG_RETRY_TIMEOUT = 3'd3,
        CFG_MAX_RETRIES   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_RESOLVE = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_PEND = 2'd1,
        ST_RES  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        K_RESOLVED = 3'd0,
        K_WAIT     = 3'd1,
        K_REQ      = 3'd2,
        K_REPLY    = 3'd3,
        K_RELEASE  = 3'd4,
        K_DISCARD  = 3'd5,
        K_DONE     = 3'd6
    } t_kind;

    // classified command handed from front to back
    typedef struct packed {
        t_op         op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        hold;
        logic        direct;     // resolve answered without table
        logic [47:0] direct_mac;
        logic        learn;      // well formed arp
        logic        reply;      // reply owed after learning
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT,
        BK_DONE
    } t_bk_state;

endpackage

FILE: rtl/arpc_front.sv
// arpc_front: accepts input words, classifies them, and queues commands
// depends on arpc_pkg
module arpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_operation,
    input  logic [31:0]          i_address,
    input  logic [47:0]          i_hw_address,
    input  logic [31:0]          i_target_address,
    input  logic [15:0]          i_arp_opcode,
    input  logic [15:0]          i_hw_type,
    input  logic [15:0]          i_proto_type,
    input  logic [10:0]          i_frame_length,
    input  logic                 i_hold_packet,
    input  logic [31:0]          i_host_ip,
    input  logic [47:0]          i_host_mac,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output arpc_pkg::t_cmd       o_cmd
);
    import arpc_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    t_cmd          c_cmd;
    logic          c_push, c_pop;

    always_comb begin
        c_cmd            = '0;
        c_cmd.op         = t_op'(i_operation);
        c_cmd.ip         = i_address;
        c_cmd.mac        = i_hw_address;
        c_cmd.hold       = i_hold_packet;
        c_cmd.direct     = (i_address == i_host_ip) || (i_address == BCAST_IP);
        c_cmd.direct_mac = (i_address == i_host_ip) ? i_host_mac : BCAST_MAC;
        c_cmd.learn      = (i_frame_length >= MIN_FRAME) && (i_hw_type == HTYPE_ETH)
                           && (i_proto_type == PTYPE_IPV4);
        c_cmd.reply      = c_cmd.learn && (i_arp_opcode == ARP_OP_REQ)
                           && (i_target_address == i_host_ip);
    end

    assign o_ready     = (r_cnt != (PW+1)'(QUEUE_DEPTH));
    assign c_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign c_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) begin
                r_q[r_wp] <= c_cmd;
                r_wp      <= r_wp + 1'b1;
            end
            if (c_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(c_push) - (PW+1)'(c_pop);
        end
    end

endmodule

FILE: rtl/arpc_back.sv
// arpc_back: walks the entry table where a command needs it and emits result words
// depends on arpc_pkg
module arpc_back #(
    parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  arpc_pkg::t_cmd       i_cmd,
    input  logic [31:0]          i_entry_timeout,
    input  logic [31:0]          i_retry_timeout,
    input  logic [2:0]           i_max_retries,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_kind,
    output logic [31:0]          o_result_ip,
    output logic [47:0]          o_result_mac,
    output logic [3:0]           o_entry_index,
    output logic                 o_held,
    output logic                 o_last
);
    import arpc_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned EW = $clog2(MAX_EVENTS + 1);

    // table, one register set per slot
    t_status     r_st   [TABLE_ENTRIES];
    logic [31:0] r_ip   [TABLE_ENTRIES];
    logic [47:0] r_mac  [TABLE_ENTRIES];
    logic [2:0]  r_rtry [TABLE_ENTRIES];
    logic [31:0] r_stmp [TABLE_ENTRIES];
    logic [31:0] r_tick;

    t_bk_state r_state, n_state;
    t_cmd      r_cmd;
    logic [IW-1:0] r_idx;
    logic          r_fr_f;
    logic [IW-1:0] r_fr;
    logic [EW-1:0] r_evcnt;

    // pending emit queue: up to two words from a resolve or receive
    logic          r_e0_v, r_e1_v;
    logic [2:0]    r_e0_k, r_e1_k;
    logic [31:0]   r_e0_ip, r_e1_ip;
    logic [47:0]   r_e0_mac, r_e1_mac;
    logic [3:0]    r_e0_ix, r_e1_ix;
    logic          r_e0_h, r_e1_h;

    // output register
    logic        r_ov;
    logic [2:0]  r_ok;
    logic [31:0] r_oip;
    logic [47:0] r_omac;
    logic [3:0]  r_oix;
    logic        r_oh, r_ol;

    logic        c_busy, c_match, c_last_idx, c_out_free;
    logic [31:0] c_age;

    assign c_out_free = !r_ov || i_ready;
    assign c_busy     = (r_st[r_idx] == ST_PEND) || (r_st[r_idx] == ST_RES);
    assign c_match    = c_busy && (r_ip[r_idx] == r_cmd.ip);
    assign c_last_idx = (r_idx == IW'(TABLE_ENTRIES - 1));
    assign c_age      = r_tick - r_stmp[r_idx];

    assign o_cmd_ready = (r_state == BK_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_cmd_valid) n_state = BK_SCAN;
            BK_SCAN: begin
                if (r_cmd.op == OP_TICK) begin
                    if (c_out_free && c_last_idx) n_state = BK_DONE;
                end else if (r_cmd.op == OP_NONE || (r_cmd.op == OP_RECEIVE && !r_cmd.learn)
                             || (r_cmd.op == OP_RESOLVE && r_cmd.direct)) begin
                    n_state = BK_EMIT;
                end else if (c_out_free && (c_match || c_last_idx)) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: if (c_out_free && !r_e0_v && !r_e1_v) n_state = BK_DONE;
            BK_DONE: if (c_out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_ok;
    assign o_result_ip   = r_oip;
    assign o_result_mac  = r_omac;
    assign o_entry_index = r_oix;
    assign o_held        = r_oh;
    assign o_last        = r_ol;

    always_ff @(posedge i_clk) begin
        logic [IW-1:0] v_slot;
        logic          v_was_pend;
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_tick  <= '0;
            r_ov    <= 1'b0;
            r_e0_v  <= 1'b0;
            r_e1_v  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) r_st[i] <= ST_FREE;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                BK_IDLE: begin
                    r_cmd   <= i_cmd;
                    r_idx   <= '0;
                    r_fr_f  <= 1'b0;
                    r_evcnt <= '0;
                    r_e0_v  <= 1'b0;
                    r_e1_v  <= 1'b0;
                    if (i_cmd_valid && i_cmd.op == OP_TICK) r_tick <= r_tick + 32'd1;
                end
                BK_SCAN: begin
                    if (r_cmd.op == OP_TICK) begin
                        if (c_out_free) begin
                            r_idx <= r_idx + 1'b1;
                            if (r_st[r_idx] == ST_RES) begin
                                if (c_age > i_entry_timeout) r_st[r_idx] <= ST_FREE;
                            end else if (r_st[r_idx] == ST_PEND && c_age >= i_retry_timeout) begin
                                if (r_evcnt != EW'(MAX_EVENTS)) begin
                                    r_ov    <= 1'b1;
                                    r_evcnt <= r_evcnt + 1'b1;
                                end
                                r_oip  <= r_ip[r_idx];
                                r_omac <= '0;
                                r_oix  <= 4'(r_idx);
                                r_oh   <= 1'b0;
                                r_ol   <= 1'b0;
                                if (r_rtry[r_idx] < i_max_retries) begin
                                    r_rtry[r_idx] <= r_rtry[r_idx] + 3'd1;
                                    r_stmp[r_idx] <= r_tick;
                                    r_ok          <= K_REQ;
                                end else begin
                                    r_st[r_idx] <= ST_FREE;
                                    r_ok        <= K_DISCARD;
                                end
                            end
                        end
                    end else if (r_cmd.op == OP_NONE
                                 || (r_cmd.op == OP_RECEIVE && !r_cmd.learn)) begin
                        r_e0_v <= 1'b0;
                    end else if (r_cmd.op == OP_RESOLVE && r_cmd.direct) begin
                        r_e0_v   <= 1'b1;
                        r_e0_k   <= K_RESOLVED;
                        r_e0_ip  <= r_cmd.ip;
                        r_e0_mac <= r_cmd.direct_mac;
                        r_e0_ix  <= '0;
                        r_e0_h   <= 1'b0;
                    end else if (c_out_free) begin
                        // scan waits while the output register is full, so an eviction discard can be placed
                        r_idx <= r_idx + 1'b1;
                        if (!c_busy && !r_fr_f) begin
                            r_fr_f <= 1'b1;
                            r_fr   <= r_idx;
                        end
                        if (c_match || c_last_idx) begin
                            // decide this command with the last slot folded in
                            if (r_cmd.op == OP_RESOLVE) begin
                                if (c_match) begin
                                    r_e0_v   <= 1'b1;
                                    r_e0_ip  <= r_cmd.ip;
                                    r_e0_ix  <= 4'(r_idx);
                                    if (r_st[r_idx] == ST_RES) begin
                                        r_e0_k   <= K_RESOLVED;
                                        r_e0_mac <= r_mac[r_idx];
                                        r_e0_h   <= 1'b0;
                                    end else begin
                                        r_e0_k   <= K_WAIT;
                                        r_e0_mac <= '0;
                                        r_e0_h   <= r_cmd.hold;
                                    end
                                end else begin
                                    v_slot = r_fr_f ? r_fr : (!c_busy ? r_idx : '0);
                                    if (!r_fr_f && c_busy && r_st[0] == ST_PEND) begin
                                        r_ov   <= 1'b1;
                                        r_ok   <= K_DISCARD;
                                        r_oip  <= r_ip[0];
                                        r_omac <= '0;
                                        r_oix  <= '0;
                                        r_oh   <= 1'b0;
                                        r_ol   <= 1'b0;
                                    end
                                    r_ip[v_slot]   <= r_cmd.ip;
                                    r_mac[v_slot]  <= '0;
                                    r_st[v_slot]   <= ST_PEND;
                                    r_rtry[v_slot] <= 3'd1;
                                    r_stmp[v_slot] <= r_tick;
                                    r_e0_v   <= 1'b1;
                                    r_e0_k   <= K_WAIT;
                                    r_e0_ip  <= r_cmd.ip;
                                    r_e0_mac <= '0;
                                    r_e0_ix  <= 4'(v_slot);
                                    r_e0_h   <= r_cmd.hold;
                                    r_e1_v   <= 1'b1;
                                    r_e1_k   <= K_REQ;
                                    r_e1_ip  <= r_cmd.ip;
                                    r_e1_mac <= '0;
                                    r_e1_ix  <= 4'(v_slot);
                                    r_e1_h   <= 1'b0;
                                end
                            end else begin
                                // learn sender
                                v_slot = c_match ? r_idx : (r_fr_f ? r_fr : r_idx);
                                v_was_pend = c_match && (r_st[r_idx] == ST_PEND);
                                if (c_match || r_fr_f || !c_busy) begin
                                    r_ip[v_slot]   <= r_cmd.ip;
                                    r_mac[v_slot]  <= r_cmd.mac;
                                    r_st[v_slot]   <= ST_RES;
                                    r_stmp[v_slot] <= r_tick;
                                    r_rtry[v_slot] <= 3'd0;
                                end
                                r_e0_v   <= v_was_pend;
                                r_e0_k   <= K_RELEASE;
                                r_e0_ip  <= r_cmd.ip;
                                r_e0_mac <= r_cmd.mac;
                                r_e0_ix  <= 4'(v_slot);
                                r_e0_h   <= 1'b0;
                                r_e1_v   <= r_cmd.reply;
                                r_e1_k   <= K_REPLY;
                                r_e1_ip  <= r_cmd.ip;
                                r_e1_mac <= r_cmd.mac;
                                r_e1_ix  <= '0;
                                r_e1_h   <= 1'b0;
                            end
                        end
                    end
                end
                BK_EMIT: begin
                    if (c_out_free) begin
                        if (r_e0_v) begin
                            r_ov   <= 1'b1;
                            r_ok   <= r_e0_k;
                            r_oip  <= r_e0_ip;
                            r_omac <= r_e0_mac;
                            r_oix  <= r_e0_ix;
                            r_oh   <= r_e0_h;
                            r_ol   <= 1'b0;
                            r_e0_v <= 1'b0;
                        end else if (r_e1_v) begin
                            r_ov   <= 1'b1;
                            r_ok   <= r_e1_k;
                            r_oip  <= r_e1_ip;
                            r_omac <= r_e1_mac;
                            r_oix  <= r_e1_ix;
                            r_oh   <= r_e1_h;
                            r_ol   <= 1'b0;
                            r_e1_v <= 1'b0;
                        end
                    end
                end
                BK_DONE: begin
                    if (c_out_free) begin
                        r_ov   <= 1'b1;
                        r_ok   <= K_DONE;
                        r_oip  <= '0;
                        r_omac <= '0;
                        r_oix  <= '0;
                        r_oh   <= 1'b0;
                        r_ol   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/arp_cache_engine.sv
// arp_cache_engine: top level of the arp address cache
// depends on arpc_pkg, arpc_front, arpc_back
//
// usage:
//  - input channel (i_valid/o_ready) takes one word per operation: resolve,
//    received arp frame fields, or timer tick
//  - output channel (o_valid/i_ready) returns the result words of that
//    operation; the final word of each operation has o_last set (kind done)
//  - configuration: i_cfg_we/i_cfg_idx/i_cfg_data, written only while idle
//  - the front classifies words (host/broadcast match, frame checks) and
//    places them in a two-word command queue, so inputs are taken while the
//    back is still busy
//  - the back walks the table one slot per cycle while the output register
//    can take a word
//  - the table scan is the limiting loop; one operation at a time is run
//  - reset frees all slots and clears the tick counter; no clearing pass
//  - a stalled receiver holds the output register and the scan waits with it
module arp_cache_engine #(
    parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_operation,
    input  logic [31:0]                     i_address,
    input  logic [47:0]                     i_hw_address,
    input  logic [31:0]                     i_target_address,
    input  logic [15:0]                     i_arp_opcode,
    input  logic [15:0]                     i_hw_type,
    input  logic [15:0]                     i_proto_type,
    input  logic [10:0]                     i_frame_length,
    input  logic                            i_hold_packet,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [2:0]                      o_kind,
    output logic [31:0]                     o_result_ip,
    output logic [47:0]                     o_result_mac,
    output logic [3:0]                      o_entry_index,
    output logic                            o_held,
    output logic                            o_last
);
    import arpc_pkg::*;

    // configuration registers
    logic [31:0] r_host_ip, r_entry_timeout, r_retry_timeout;
    logic [47:0] r_host_mac;
    logic [2:0]  r_max_retries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_ip       <= '0;
            r_host_mac      <= '0;
            r_entry_timeout <= 32'd300;
            r_retry_timeout <= 32'd1;
            r_max_retries   <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HOST_IP:       r_host_ip       <= i_cfg_data[31:0];
                CFG_HOST_MAC:      r_host_mac      <= i_cfg_data[47:0];
                CFG_ENTRY_TIMEOUT: r_entry_timeout <= i_cfg_data[31:0];
                CFG_RETRY_TIMEOUT: r_retry_timeout <= i_cfg_data[31:0];
                CFG_MAX_RETRIES:   r_max_retries   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // front to back command queue
    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    arpc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .i_hw_address     (i_hw_address),
        .i_target_address (i_target_address),
        .i_arp_opcode     (i_arp_opcode),
        .i_hw_type        (i_hw_type),
        .i_proto_type     (i_proto_type),
        .i_frame_length   (i_frame_length),
        .i_hold_packet    (i_hold_packet),
        .i_host_ip        (r_host_ip),
        .i_host_mac       (r_host_mac),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_ready      (cmd_ready),
        .o_cmd            (cmd)
    );

    arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd           (cmd),
        .i_entry_timeout (r_entry_timeout),
        .i_retry_timeout (r_retry_timeout),
        .i_max_retries   (r_max_retries),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_result_ip     (o_result_ip),
        .o_result_mac    (o_result_mac),
        .o_entry_index   (o_entry_index),
        .o_held          (o_held),
        .o_last          (o_last)
    );

endmodule
